>>> hw/rtl/lkat_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the lowest-K average temperature filter.
// No dependencies; imported by every module of the block.
package lkat_pkg;

  localparam int RAW_W        = 16;
  localparam int CNT_W        = 8;
  localparam int OUT_W        = 18;
  localparam int KEEP         = 3;
  localparam int SUM_W        = RAW_W + $clog2(KEEP);
  localparam int DBL_W        = SUM_W + 1;
  localparam int DIV_SHIFT    = 24;
  localparam int RECIP_W      = DIV_SHIFT + 1;
  localparam int DIV_RECIP    = ((1 << DIV_SHIFT) + KEEP - 1) / KEEP;
  localparam int PROD_W       = DBL_W + RECIP_W;
  localparam int QUO_W        = PROD_W - DIV_SHIFT;
  localparam int CENTI_OFFSET = 27315;
  localparam int WINDOW_RESET = 20;

  localparam int CFG_ADDR_W   = 3;
  localparam int CFG_DATA_W   = 32;
  localparam logic REG_WINDOW_LEN = 1'b0;

  typedef logic [RAW_W-1:0] raw_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [SUM_W-1:0] sum_t;

  typedef struct packed {
    logic vld;
    sum_t sum;
  } win_t;

endpackage

>>> hw/rtl/lkat_sort.sv
`timescale 1ns / 1ps
// Input register, sorted list of the smallest readings and sample counter.
// Emits the registered sum of the kept list at the end of each window. Uses lkat_pkg.
module lkat_sort (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  lkat_pkg::raw_t     in_raw_reading,
  input  lkat_pkg::cnt_t     window_len,
  output lkat_pkg::win_t     win,
  input  logic               win_stall
);
  import lkat_pkg::*;

  logic             a_vld_r, a_vld_nxt;
  raw_t             a_raw_r;
  raw_t             list_r [KEEP];
  raw_t             list_nxt [KEEP];
  cnt_t             cnt_r, cnt_nxt;
  logic             win_vld_r, win_vld_nxt;
  sum_t             win_sum_r, win_sum_nxt;
  logic             a_go;
  logic             b_go;
  logic             accept;
  logic [CNT_W:0]   count;
  logic             win_end;
  sum_t             acc;

  assign b_go     = win_vld_r && !win_stall;
  assign a_go     = a_vld_r && (!win_vld_r || !win_stall);
  assign in_stall = a_vld_r && !a_go;
  assign accept   = in_valid && !in_stall;

  assign count   = {1'b0, cnt_r} + (CNT_W+1)'(1);
  assign win_end = count >= {1'b0, window_len};

  always_comb begin
    acc = '0;
    for (int i = 0; i < KEEP; i++) begin
      if (i > 0 && a_raw_r < list_r[(i > 0) ? i-1 : 0]) begin
        list_nxt[i] = list_r[(i > 0) ? i-1 : 0];
      end else begin
        list_nxt[i] = (a_raw_r < list_r[i]) ? a_raw_r : list_r[i];
      end
      acc = acc + SUM_W'(list_nxt[i]);
    end
  end

  always_comb begin
    a_vld_nxt   = a_vld_r;
    cnt_nxt     = cnt_r;
    win_vld_nxt = win_vld_r;
    win_sum_nxt = win_sum_r;
    if (accept) begin
      a_vld_nxt = 1'b1;
    end else if (a_go) begin
      a_vld_nxt = 1'b0;
    end
    if (b_go) begin
      win_vld_nxt = 1'b0;
    end
    if (a_go) begin
      if (win_end) begin
        cnt_nxt     = '0;
        win_vld_nxt = 1'b1;
        win_sum_nxt = acc;
      end else begin
        cnt_nxt = count[CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r   <= 1'b0;
      cnt_r     <= '0;
      win_vld_r <= 1'b0;
      for (int i = 0; i < KEEP; i++) begin
        list_r[i] <= '1;
      end
    end else begin
      a_vld_r   <= a_vld_nxt;
      cnt_r     <= cnt_nxt;
      win_vld_r <= win_vld_nxt;
      if (a_go) begin
        for (int i = 0; i < KEEP; i++) begin
          list_r[i] <= win_end ? '1 : list_nxt[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_raw_r <= in_raw_reading;
    end
    win_sum_r <= win_sum_nxt;
  end

  assign win.vld = win_vld_r;
  assign win.sum = win_sum_r;

endmodule

>>> hw/rtl/lkat_scale.sv
`timescale 1ns / 1ps
// Mean and Celsius conversion: floor(2*sum/KEEP) - 27315 into the output register.
// Divides by reciprocal multiplication. Uses lkat_pkg.
module lkat_scale (
  input  logic                         clk,
  input  logic                         rst_n,
  input  lkat_pkg::win_t               win,
  output logic                         win_stall,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [lkat_pkg::OUT_W-1:0] out_avg_temp_centi
);
  import lkat_pkg::*;

  logic              out_vld_r, out_vld_nxt;
  logic [OUT_W-1:0]  out_data_r;
  logic [OUT_W-1:0]  out_data_nxt;
  logic [DBL_W-1:0]  dbl;
  logic [PROD_W-1:0] prod;
  logic [QUO_W-1:0]  quo;
  logic              b_go;

  assign win_stall = out_vld_r && out_stall;
  assign b_go      = win.vld && !win_stall;

  assign dbl          = {win.sum, 1'b0};
  assign prod         = PROD_W'(dbl) * PROD_W'(DIV_RECIP);
  assign quo          = prod[PROD_W-1:DIV_SHIFT];
  assign out_data_nxt = quo[OUT_W-1:0] - OUT_W'(CENTI_OFFSET);

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (b_go) begin
      out_vld_nxt = 1'b1;
    end else if (out_vld_r && !out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (b_go) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_avg_temp_centi = $signed(out_data_r);

endmodule

>>> hw/rtl/lowest_k_average_temp_filter_top.sv
`timescale 1ns / 1ps
// Lowest-K average temperature filter, top level with the configuration registers.
// A window-ending transaction passes the input, window and output registers to out_valid.
// Throughput: one transaction per cycle while unstalled; insert and window sum in the same cycle.
// Reset (synchronous, rst_n low): list emptied to all ones, count zero, window_len 20.
// Depends on lkat_pkg, lkat_sort and lkat_scale.
module lowest_k_average_temp_filter_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [lkat_pkg::RAW_W-1:0]          in_raw_reading,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [lkat_pkg::OUT_W-1:0]   out_avg_temp_centi,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [lkat_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [lkat_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [lkat_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                cfg_pready
);
  import lkat_pkg::*;

  cnt_t  window_len_r;
  win_t  win;
  logic  win_stall;
  logic  cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_len_r <= CNT_W'(WINDOW_RESET);
    end else if (cfg_wr && cfg_paddr[2] == REG_WINDOW_LEN) begin
      window_len_r <= cfg_pwdata[CNT_W-1:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == REG_WINDOW_LEN) begin
      cfg_prdata = CFG_DATA_W'(window_len_r);
    end
  end

  lkat_sort u_sort (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_raw_reading (in_raw_reading),
    .window_len     (window_len_r),
    .win            (win),
    .win_stall      (win_stall)
  );

  lkat_scale u_scale (
    .clk                (clk),
    .rst_n              (rst_n),
    .win                (win),
    .win_stall          (win_stall),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_avg_temp_centi (out_avg_temp_centi)
  );

`ifndef NO_ASSERTIONS
  a_in_stall_needs_full_win: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> win.vld)
    else $error("input stalled while window stage is empty");

  a_win_stall_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    win_stall |-> out_valid)
    else $error("window stage stalled without a pending result");

  a_win_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (win.vld && win_stall) |=> (win.vld && $stable(win.sum)))
    else $error("stalled window sum lost or changed");

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");
`endif

endmodule

>>> tb/tb_lowest_k_average_temp_filter_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for lowest_k_average_temp_filter_top: directed and random
// readings, window_len programmed over the APB port. Depends on lkat_pkg and the RTL.
module tb_lowest_k_average_temp_filter_top;
  import lkat_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] WINDOW_LEN_ADDR = CFG_ADDR_W'(4 * REG_WINDOW_LEN);
  localparam int RANDOM_ITEMS = 1250;
  localparam int SETTLE_CYCLES = 4;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [RAW_W-1:0]        in_raw_reading = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [OUT_W-1:0] out_avg_temp_centi;
  logic                    cfg_psel = 1'b0;
  logic                    cfg_penable = 1'b0;
  logic                    cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0]   cfg_paddr = '0;
  logic [CFG_DATA_W-1:0]   cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0]   cfg_prdata;
  logic                    cfg_pready;

  raw_t             kept_lowest [KEEP];
  cnt_t             taken_count;
  cnt_t             window_setting;
  logic [OUT_W-1:0] expected_temps [$];
  int               err_count = 0;
  int               burst_left = 0;
  int               random_sent = 0;
  raw_t             last_reading = '0;
  int               stall_mode = 0;
  int               stall_left = 0;
  int               pattern_cycles = 0;

  lowest_k_average_temp_filter_top u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_raw_reading     (in_raw_reading),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_avg_temp_centi (out_avg_temp_centi),
    .cfg_psel           (cfg_psel),
    .cfg_penable        (cfg_penable),
    .cfg_pwrite         (cfg_pwrite),
    .cfg_paddr          (cfg_paddr),
    .cfg_pwdata         (cfg_pwdata),
    .cfg_prdata         (cfg_prdata),
    .cfg_pready         (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #3_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  function automatic logic [OUT_W-1:0] window_average();
    int unsigned total;
    total = 0;
    foreach (kept_lowest[i]) total += kept_lowest[i];
    return OUT_W'((2 * total) / KEEP - CENTI_OFFSET);
  endfunction

  task automatic track_reading(input raw_t x);
    raw_t        nxt [KEEP];
    int unsigned count;
    for (int i = 0; i < KEEP; i++) begin
      if (i > 0 && x < kept_lowest[i-1]) nxt[i] = kept_lowest[i-1];
      else nxt[i] = (x < kept_lowest[i]) ? x : kept_lowest[i];
    end
    kept_lowest = nxt;
    count = taken_count + 1;
    if (count < window_setting) begin
      taken_count = cnt_t'(count);
    end else begin
      expected_temps.push_back(window_average());
      foreach (kept_lowest[i]) kept_lowest[i] = '1;
      taken_count = '0;
    end
  endtask

  task automatic send_reading(input raw_t x);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 4);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid       <= 1'b1;
    in_raw_reading <= x;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    track_reading(x);
  endtask

  task automatic drain_results();
    in_valid   <= 1'b0;
    burst_left = 0;
    while (expected_temps.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_window_len(input cnt_t value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= WINDOW_LEN_ADDR;
    cfg_pwdata  <= CFG_DATA_W'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    window_setting = value;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (cfg_prdata !== CFG_DATA_W'(value))
      report_mismatch($sformatf("window_len readback %0h, wrote %0h", cfg_prdata, value));
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  function automatic raw_t pick_reading();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return raw_t'($urandom);
      4:          return raw_t'($urandom_range(0, 15));
      5:          return raw_t'($urandom_range(65520, 65535));
      6:          return last_reading;
      7:          return raw_t'(1 << $urandom_range(0, RAW_W - 1));
      default:    return raw_t'($urandom_range(13000, 20000));
    endcase
  endfunction

  // Hold the reset value of window_len; mix extremes, alternating bits and ties.
  task automatic test_default_window();
    raw_t readings [20];
    readings = '{16'hFFFF, 16'h0000, 16'h0000, 16'h0001, 16'hFFFF,
                 16'h8000, 16'h7FFF, 16'hAAAA, 16'h5555, 16'h3A98,
                 16'h3A98, 16'hFFFE, 16'h00FF, 16'hFF00, 16'h0F0F,
                 16'hF0F0, 16'h0002, 16'h0001, 16'h1234, 16'hFFFF};
    foreach (readings[i]) send_reading(readings[i]);
    drain_results();
  endtask

  // Windows of one, zero and two: empty slots enter the sum as all ones.
  task automatic test_tiny_windows();
    write_window_len(8'd1);
    send_reading(16'hFFFF);
    send_reading(16'h0000);
    drain_results();
    write_window_len(8'd0);
    send_reading(16'h0000);
    send_reading(16'h0007);
    drain_results();
    write_window_len(8'd2);
    send_reading(16'd100);
    send_reading(16'd50);
    drain_results();
  endtask

  // Lower window_len below the running count: the next transaction closes the window.
  task automatic test_lowered_window();
    write_window_len(8'd20);
    for (int i = 0; i < 8; i++) send_reading(raw_t'($urandom_range(14000, 16000)));
    drain_results();
    write_window_len(8'd3);
    send_reading(16'd15000);
    drain_results();
  endtask

  task automatic test_random_windows();
    int   pick;
    int   windows;
    int   extra;
    cnt_t wlen;
    while (random_sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 19);
      case (pick)
        0:       wlen = 8'd255;
        1:       wlen = cnt_t'($urandom_range(0, 2));
        2, 3:    wlen = 8'd3;
        default: wlen = cnt_t'($urandom_range(3, 16));
      endcase
      write_window_len(wlen);
      windows = (wlen > 16) ? 1 : $urandom_range(1, 6);
      extra = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 12) : 0;
      for (int i = 0; i < windows * ((wlen == 0) ? 1 : wlen) + extra; i++) begin
        last_reading = pick_reading();
        send_reading(last_reading);
        random_sent++;
      end
      drain_results();
    end
  endtask

  always @(posedge clk) begin
    logic stall_next;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      pattern_cycles++;
      if (pattern_cycles % 300 == 0) stall_mode = $urandom_range(0, 2);
      stall_next = 1'b0;
      case (stall_mode)
        1: stall_next = ($urandom_range(0, 3) == 0);
        2: begin
          if (stall_left == 0 && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 12);
          if (stall_left > 0) begin
            stall_next = 1'b1;
            stall_left--;
          end
        end
        default: stall_next = 1'b0;
      endcase
      out_stall <= stall_next;
    end
  end

  always @(posedge clk) begin
    logic [OUT_W-1:0] want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_temps.size() == 0) begin
        report_mismatch($sformatf("unexpected result %0d", out_avg_temp_centi));
      end else begin
        want = expected_temps.pop_front();
        if (out_avg_temp_centi !== want)
          report_mismatch($sformatf("avg_temp_centi %0d, expected %0d",
                                    out_avg_temp_centi, $signed(want)));
      end
    end
  end

  initial begin
    foreach (kept_lowest[i]) kept_lowest[i] = '1;
    taken_count    = '0;
    window_setting = cnt_t'(WINDOW_RESET);
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_window();
    test_tiny_windows();
    test_lowered_window();
    test_random_windows();
    drain_results();
    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
